[src/lce_pkg.sv]
// Shared widths, codes and control bundles of the LRU cache with expiry.
`timescale 1ns / 1ps

package lce_pkg;

  // Fixed port widths.
  localparam int unsigned KEY_IN_W   = 32;
  localparam int unsigned VALUE_IN_W = 64;
  localparam int unsigned TTL_W      = 32;
  localparam int unsigned TIME_W     = 40;
  localparam int unsigned EXP_W      = 41;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_W      = 5;

  // Transaction kinds.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Result codes.
  localparam logic [STATUS_W-1:0] ST_MISS         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT          = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STORED       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STORED_EVICT = 3'd4;

  // Control part of the packet that travels down the cell row.
  typedef struct packed {
    logic active;    // packet present at this hop
    logic shifting;  // cells still take the carry and pass their own entry on
    logic found;     // the carry holds the entry that matched the key
  } pkt_ctrl_t;

  // Per-cell commands of the finishing cycle.
  typedef struct packed {
    logic load;  // take the entry offered on the load inputs
    logic kill;  // drop the entry held
  } fin_ctrl_t;

endpackage

[src/lce_cell.sv]
// One cache slot of the recency-ordered cell row, with its packet hop register.
`timescale 1ns / 1ps

module lce_cell #(
  parameter int unsigned KEY_W = 32,
  parameter int unsigned VAL_W = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [KEY_W-1:0]          lookup_key_i,
  input  lce_pkg::pkt_ctrl_t        ctrl_i,
  input  logic                      c_valid_i,
  input  logic [KEY_W-1:0]          c_key_i,
  input  logic [VAL_W-1:0]          c_value_i,
  input  logic [lce_pkg::EXP_W-1:0] c_expiry_i,
  input  lce_pkg::fin_ctrl_t        fin_i,
  input  logic                      ld_valid_i,
  input  logic [KEY_W-1:0]          ld_key_i,
  input  logic [VAL_W-1:0]          ld_value_i,
  input  logic [lce_pkg::EXP_W-1:0] ld_expiry_i,
  output lce_pkg::pkt_ctrl_t        ctrl_o,
  output logic                      c_valid_o,
  output logic [KEY_W-1:0]          c_key_o,
  output logic [VAL_W-1:0]          c_value_o,
  output logic [lce_pkg::EXP_W-1:0] c_expiry_o,
  output logic                      ent_valid_o,
  output logic [KEY_W-1:0]          ent_key_o,
  output logic [VAL_W-1:0]          ent_value_o,
  output logic [lce_pkg::EXP_W-1:0] ent_expiry_o
);

  logic                      v_q, v_d;
  logic [KEY_W-1:0]          k_q;
  logic [VAL_W-1:0]          val_q;
  logic [lce_pkg::EXP_W-1:0] exp_q;
  lce_pkg::pkt_ctrl_t        octrl_q, octrl_d;
  logic                      ocv_q, ocv_d;
  logic [KEY_W-1:0]          ok_q;
  logic [VAL_W-1:0]          oval_q;
  logic [lce_pkg::EXP_W-1:0] oexp_q;
  logic                      scan;
  logic                      hit;

  assign scan = ctrl_i.active && ctrl_i.shifting;
  assign hit  = v_q && (k_q == lookup_key_i);

  always_comb begin
    v_d            = v_q;
    octrl_d        = octrl_q;
    ocv_d          = ocv_q;
    octrl_d.active = ctrl_i.active;
    if (scan) begin
      // Take the carry, hand our own entry on; stop at a match or at the end of the list.
      v_d              = c_valid_i;
      octrl_d.shifting = v_q && !hit;
      octrl_d.found    = hit;
      ocv_d            = v_q;
    end else if (ctrl_i.active) begin
      octrl_d = ctrl_i;
      ocv_d   = c_valid_i;
    end else if (fin_i.load) begin
      v_d = ld_valid_i;
    end else if (fin_i.kill) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      octrl_q <= '0;
      ocv_q   <= 1'b0;
    end else begin
      v_q     <= v_d;
      octrl_q <= octrl_d;
      ocv_q   <= ocv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan) begin
      k_q    <= c_key_i;
      val_q  <= c_value_i;
      exp_q  <= c_expiry_i;
      ok_q   <= k_q;
      oval_q <= val_q;
      oexp_q <= exp_q;
    end else if (ctrl_i.active) begin
      ok_q   <= c_key_i;
      oval_q <= c_value_i;
      oexp_q <= c_expiry_i;
    end else if (fin_i.load) begin
      k_q   <= ld_key_i;
      val_q <= ld_value_i;
      exp_q <= ld_expiry_i;
    end
  end

  assign ctrl_o       = octrl_q;
  assign c_valid_o    = ocv_q;
  assign c_key_o      = ok_q;
  assign c_value_o    = oval_q;
  assign c_expiry_o   = oexp_q;
  assign ent_valid_o  = v_q;
  assign ent_key_o    = k_q;
  assign ent_value_o  = val_q;
  assign ent_expiry_o = exp_q;

endmodule

[src/lru_cache_with_expiry_core.sv]
// Top level of the fully associative LRU key-value cache with per-entry expiry.
//
// Usage: an input transaction (in_valid_i high, in_stall_o low) carries one get or
// put request; each request yields exactly one result transaction on the output
// channel (out_valid_o high, out_stall_i low) with a status code and, on a hit,
// the stored value. The capacity register is written through its own valid/ready
// port and must only be written while no request is outstanding.
// The request packet walks the cell row through the hop register of each cell; the
// sequencer then sees the packet leave the row, and its finishing state writes the
// result register and returns to idle. A new request is taken only in the idle
// state, not before the previous request has finished. in_stall_o is high while a
// request is in flight; the next request is taken while a finished result still
// waits. Stalling the output holds the result register and, if a second request
// has finished behind it, holds that request in its finishing cycle.
// Reset empties the cache (all slot valid bits clear), sets the capacity to 16 and
// drops any request or result in flight.
`timescale 1ns / 1ps

module lru_cache_with_expiry_core #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [lce_pkg::KEY_IN_W-1:0]   key_i,
  input  logic [lce_pkg::VALUE_IN_W-1:0] value_in_i,
  input  logic [lce_pkg::TTL_W-1:0]      ttl_i,
  input  logic [lce_pkg::TIME_W-1:0]     current_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lce_pkg::STATUS_W-1:0]   status_o,
  output logic [lce_pkg::VALUE_IN_W-1:0] value_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lce_pkg::CFG_W-1:0]      cfg_data_i
);

  // Only the low key bits that fit the key port take part in matching.
  localparam int unsigned KeyW = (KEY_BITS < lce_pkg::KEY_IN_W) ? KEY_BITS : lce_pkg::KEY_IN_W;
  localparam int unsigned CntW = $clog2(CAPACITY + 2);
  localparam int unsigned CapW = (CntW > lce_pkg::CFG_W) ? CntW : lce_pkg::CFG_W;
  localparam int unsigned Last = CAPACITY - 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e                           state_q;
  logic                             inj_active_q;
  logic                             req_act_q;
  logic [KeyW-1:0]                  req_key_q;
  logic [VALUE_BITS-1:0]            req_val_q;
  logic [lce_pkg::EXP_W-1:0]        req_exp_q;
  logic [lce_pkg::TIME_W-1:0]       req_now_q;
  logic [CntW-1:0]                  count_q, count_d;
  logic [lce_pkg::CFG_W-1:0]        cap_q;
  logic                             out_valid_q;
  logic [lce_pkg::STATUS_W-1:0]     status_q, status_d;
  logic [lce_pkg::VALUE_IN_W-1:0]   value_out_q, value_out_d;

  // Packet hops: stage i feeds cell i, stage CAPACITY is the row's exit.
  lce_pkg::pkt_ctrl_t               ctrl_s  [CAPACITY+1];
  logic                             cv_s    [CAPACITY+1];
  logic [KeyW-1:0]                  ck_s    [CAPACITY+1];
  logic [VALUE_BITS-1:0]            cval_s  [CAPACITY+1];
  logic [lce_pkg::EXP_W-1:0]        cexp_s  [CAPACITY+1];

  // Entries held by the cells, for the neighbor load in the finishing cycle.
  logic                             ev_s    [CAPACITY];
  logic [KeyW-1:0]                  ek_s    [CAPACITY];
  logic [VALUE_BITS-1:0]            eval_s  [CAPACITY];
  logic [lce_pkg::EXP_W-1:0]        eexp_s  [CAPACITY];

  lce_pkg::fin_ctrl_t               fin_s   [CAPACITY];
  logic [CAPACITY-1:0]              kill_vec;

  logic                             in_accept;
  logic                             fin_go;
  logic                             is_put;
  logic                             found;
  logic                             expired;
  logic                             shift_up;
  logic                             front;
  logic                             evict;
  logic [CntW-1:0]                  cnt_tmp;
  logic [CntW-1:0]                  remain;
  logic [CntW-1:0]                  kill_pos;
  logic [CapW-1:0]                  cap_ext;
  logic [CapW-1:0]                  cap_eff;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lce_pkg::CFG_W'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // A capacity of zero acts as one; anything above the slot count acts as the slot count.
  assign cap_ext = CapW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CapW'(1);
    end else if (cap_ext > CapW'(CAPACITY)) begin
      cap_eff = CapW'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Request registers; the expiry stamp is formed as the request is taken.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_act_q <= action_i;
      req_key_q <= key_i[KeyW-1:0];
      req_val_q <= value_in_i[VALUE_BITS-1:0];
      req_exp_q <= lce_pkg::EXP_W'(current_time_i) + lce_pkg::EXP_W'(ttl_i);
      req_now_q <= current_time_i;
    end
  end

  // A get launches a hole into the row, a put launches the new entry itself.
  assign ctrl_s[0] = '{active: inj_active_q, shifting: 1'b1, found: 1'b0};
  assign cv_s[0]   = (req_act_q == lce_pkg::ACT_PUT);
  assign ck_s[0]   = req_key_q;
  assign cval_s[0] = req_val_q;
  assign cexp_s[0] = req_exp_q;

  // Decide the finishing action from what left the end of the row. After the
  // walk, every entry ahead of the match (or all entries on a miss) sits one
  // place further down, with the launched carry in front.
  assign is_put  = (req_act_q == lce_pkg::ACT_PUT);
  assign found   = ctrl_s[CAPACITY].found;
  assign expired = lce_pkg::EXP_W'(req_now_q) > cexp_s[CAPACITY];
  assign fin_go  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // A live hit goes back to the front; a miss or an expired entry closes the gap.
  assign front    = !is_put && found && !expired;
  assign shift_up = !is_put && !(found && !expired);

  // On a put the matching entry, if any, was swallowed by the walk; without a
  // match the list grew by one and the oldest entry may have dropped off the end.
  assign cnt_tmp  = found ? count_q : count_q + CntW'(1);
  assign remain   = found ? count_q - CntW'(1) : count_q;
  assign evict    = CapW'(remain) >= cap_eff;
  assign kill_pos = cnt_tmp - CntW'(1);

  always_comb begin
    count_d     = count_q;
    status_d    = lce_pkg::ST_MISS;
    value_out_d = '0;
    if (is_put) begin
      status_d = evict ? lce_pkg::ST_STORED_EVICT : lce_pkg::ST_STORED;
      count_d  = evict ? cnt_tmp - CntW'(1) : cnt_tmp;
    end else if (!found) begin
      status_d = lce_pkg::ST_MISS;
    end else if (expired) begin
      status_d = lce_pkg::ST_EXPIRED;
      count_d  = count_q - CntW'(1);
    end else begin
      status_d    = lce_pkg::ST_HIT;
      value_out_d = lce_pkg::VALUE_IN_W'(cval_s[CAPACITY]);
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      inj_active_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= lce_pkg::ST_MISS;
      value_out_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !fin_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            inj_active_q <= 1'b1;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          inj_active_q <= 1'b0;
          if (ctrl_s[CAPACITY].active) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            count_q     <= count_d;
            status_q    <= status_d;
            value_out_q <= value_out_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_out_q;

  // The cell row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      ld_valid;
    logic [KeyW-1:0]           ld_key;
    logic [VALUE_BITS-1:0]     ld_value;
    logic [lce_pkg::EXP_W-1:0] ld_expiry;

    if (i == 0) begin : g_head
      // The head takes the hit entry back, or its neighbor's entry on a shift.
      assign ld_valid  = front ? cv_s[CAPACITY]   : ev_s[1];
      assign ld_key    = front ? ck_s[CAPACITY]   : ek_s[1];
      assign ld_value  = front ? cval_s[CAPACITY] : eval_s[1];
      assign ld_expiry = front ? cexp_s[CAPACITY] : eexp_s[1];
    end else if (i == Last) begin : g_tail
      // The tail takes back an entry that overflowed on a miss, else a hole.
      assign ld_valid  = cv_s[CAPACITY] && !found;
      assign ld_key    = ck_s[CAPACITY];
      assign ld_value  = cval_s[CAPACITY];
      assign ld_expiry = cexp_s[CAPACITY];
    end else begin : g_mid
      assign ld_valid  = ev_s[i+1];
      assign ld_key    = ek_s[i+1];
      assign ld_value  = eval_s[i+1];
      assign ld_expiry = eexp_s[i+1];
    end

    assign kill_vec[i]   = fin_go && is_put && evict && (kill_pos == CntW'(i));
    assign fin_s[i].kill = kill_vec[i];
    assign fin_s[i].load = fin_go && (shift_up || (front && (i == 0)));

    lce_cell #(
      .KEY_W (KeyW),
      .VAL_W (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .lookup_key_i (req_key_q),
      .ctrl_i       (ctrl_s[i]),
      .c_valid_i    (cv_s[i]),
      .c_key_i      (ck_s[i]),
      .c_value_i    (cval_s[i]),
      .c_expiry_i   (cexp_s[i]),
      .fin_i        (fin_s[i]),
      .ld_valid_i   (ld_valid),
      .ld_key_i     (ld_key),
      .ld_value_i   (ld_value),
      .ld_expiry_i  (ld_expiry),
      .ctrl_o       (ctrl_s[i+1]),
      .c_valid_o    (cv_s[i+1]),
      .c_key_o      (ck_s[i+1]),
      .c_value_o    (cval_s[i+1]),
      .c_expiry_o   (cexp_s[i+1]),
      .ent_valid_o  (ev_s[i]),
      .ent_key_o    (ek_s[i]),
      .ent_value_o  (eval_s[i]),
      .ent_expiry_o (eexp_s[i])
    );
  end

  // The entry count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above slot count");

  // A launched packet reaches the end of the row after exactly one hop per cell.
  a_walk_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inj_active_q |-> ##CAPACITY ctrl_s[CAPACITY].active)
    else $error("packet walk latency wrong");

  // The row only delivers a packet while the sequencer waits for it.
  a_exit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_s[CAPACITY].active |-> (state_q == S_SCAN))
    else $error("packet left the row outside the scan phase");

  // An eviction drops at most one slot.
  a_single_kill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(kill_vec))
    else $error("more than one slot dropped");

  // A finished request always leaves a result behind.
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_q)
    else $error("finished request produced no result");

endmodule
